// ===== hdl/abp_pkg.sv =====
// Package for the average pixel binning core: shared types and constants.
// Used by abp_raster, abp_accum and average_pixel_binning_core; no dependencies.
`default_nettype none

package abp_pkg;

   // Widths fixed by the stream and register formats.
   localparam int PIX_W    = 16;
   localparam int DIM_W    = 13;
   localparam int MODE_W   = 2;
   localparam int SUM_W    = 20;
   localparam int CSR_IDX_W = 2;

   // Largest frame height accepted before clamping.
   localparam logic [DIM_W-1:0] MAX_HEIGHT = 13'd4096;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIN_MODE     = 2'd0,
      CSR_PIXEL_WIDE   = 2'd1,
      CSR_FRAME_WIDTH  = 2'd2,
      CSR_FRAME_HEIGHT = 2'd3
   } csr_index_type;

   // Bin mode register codes.
   localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BIN2 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BIN4 = 2'd2;

   // How one pixel is handled.
   typedef enum logic [1:0] {
      KIND_PASS = 2'd0,
      KIND_ERR  = 2'd1,
      KIND_BIN  = 2'd2
   } kind_type;

   // Per-pixel descriptor handed from the raster tracker to the datapath.
   typedef struct packed {
      logic [PIX_W-1:0] pix;
      kind_type         kind;
      logic             quad;          // 4x4 blocks when set, 2x2 otherwise
      logic             blk_last_col;
      logic             blk_first_row;
      logic             blk_last_row;
      logic             last_col;
      logic             last_row;
   } desc_type;

endpackage : abp_pkg

`default_nettype wire

// ===== hdl/abp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module abp_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 2048,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule : abp_ram

`default_nettype wire

// ===== hdl/abp_raster.sv =====
// Configuration registers and raster position tracking for the binning core.
// Builds one descriptor per transfer. Depends on abp_pkg.
`default_nettype none

module abp_raster #(
   parameter int MAX_WIDTH  = 4096,
   parameter int PIXEL_BITS = 16,
   localparam int AW = $clog2(MAX_WIDTH / 2)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [abp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [abp_pkg::DIM_W-1:0]     csr_wdata,
   input  wire logic                          accept,
   input  wire logic [abp_pkg::PIX_W-1:0]     pixel_in,
   output abp_pkg::desc_type                  desc,
   output logic      [AW-1:0]                 col_addr
);

   import abp_pkg::*;

   localparam int W_LIMIT = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
   localparam logic [DIM_W-1:0] W_MAX = DIM_W'(W_LIMIT);
   localparam logic [PIX_W-1:0] WIDE_MASK = PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);

   logic [MODE_W-1:0] bin_mode_ff;
   logic              wide_ff;
   logic [DIM_W-1:0]  fw_ff;
   logic [DIM_W-1:0]  fh_ff;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic [DIM_W-1:0]  row_ff, row_in;

   logic [DIM_W-1:0]  w, h, x, y;
   logic              last_col, last_row;
   logic [1:0]        kmask;
   logic              is_bin, quad, geo_bad;
   logic [PIX_W-1:0]  pmask;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_mode_ff <= MODE_PASS;
         wide_ff     <= 1'b0;
         fw_ff       <= DIM_W'(1);
         fh_ff       <= DIM_W'(1);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BIN_MODE:     bin_mode_ff <= csr_wdata[MODE_W-1:0];
            CSR_PIXEL_WIDE:   wide_ff     <= csr_wdata[0];
            CSR_FRAME_WIDTH:  fw_ff       <= csr_wdata;
            CSR_FRAME_HEIGHT: fh_ff       <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // Clamped geometry and the position of the current pixel.
   always_comb begin
      w = (fw_ff == '0) ? DIM_W'(1) : ((fw_ff > W_MAX) ? W_MAX : fw_ff);
      h = (fh_ff == '0) ? DIM_W'(1) : ((fh_ff > MAX_HEIGHT) ? MAX_HEIGHT : fh_ff);
      x = (col_ff >= w) ? '0 : col_ff;
      y = (row_ff >= h) ? '0 : row_ff;
      last_col = (x == w - DIM_W'(1));
      last_row = (y == h - DIM_W'(1));
   end

   // Mode decode and block position.
   always_comb begin
      is_bin  = (bin_mode_ff == MODE_BIN2) || (bin_mode_ff == MODE_BIN4);
      quad    = (bin_mode_ff == MODE_BIN4);
      kmask   = quad ? 2'b11 : 2'b01;
      geo_bad = ((w[1:0] & kmask) != 2'b00) || ((h[1:0] & kmask) != 2'b00);
      pmask   = wide_ff ? WIDE_MASK : PIX_W'(16'h00FF);

      desc.pix           = pixel_in & pmask;
      desc.kind          = !is_bin ? KIND_PASS : (geo_bad ? KIND_ERR : KIND_BIN);
      desc.quad          = quad;
      desc.blk_last_col  = ((x[1:0] & kmask) == kmask);
      desc.blk_first_row = ((y[1:0] & kmask) == 2'b00);
      desc.blk_last_row  = ((y[1:0] & kmask) == kmask);
      desc.last_col      = last_col;
      desc.last_row      = last_row;
      col_addr           = quad ? AW'(x >> 2) : AW'(x >> 1);
   end

   // Raster counters advance on every transfer.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : y + DIM_W'(1);
         end else begin
            col_in = x + DIM_W'(1);
            row_in = y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule : abp_raster

`default_nettype wire

// ===== hdl/abp_accum.sv =====
// Binning datapath: input stage, row accumulator, column sum store and result
// register. Depends on abp_pkg and abp_ram.
`default_nettype none

module abp_accum #(
   parameter int MAX_WIDTH = 4096,
   localparam int DEPTH = MAX_WIDTH / 2,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire abp_pkg::desc_type         desc,
   input  wire logic [AW-1:0]             col_addr,
   output logic                           hold,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic      [abp_pkg::PIX_W-1:0] rsp_pixel_out,
   output logic                           rsp_end_of_row,
   output logic                           rsp_end_of_frame,
   output logic                           rsp_status
);

   import abp_pkg::*;

   logic              a_valid_ff, a_valid_in;
   desc_type          a_desc_ff;
   logic [AW-1:0]     a_addr_ff;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic              byp_ff;
   logic [SUM_W-1:0]  byp_data_ff;
   logic              b_valid_ff, b_valid_in;
   logic [PIX_W-1:0]  b_pix_ff;
   logic              b_eor_ff, b_eof_ff, b_status_ff;

   logic              a_adv, emits, is_bin, ram_we;
   logic [SUM_W-1:0]  rdata, prev, acc_sum, sum;
   logic [SUM_W:0]    rsum;
   logic [PIX_W-1:0]  mean, res_pix;

   // Column partial sum store.
   abp_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_col_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (a_addr_ff),
      .wdata (sum),
      .re    (accept),
      .raddr (col_addr),
      .rdata (rdata)
   );

   // The input stage moves on when the result register can take its result.
   assign a_adv = a_valid_ff && (!b_valid_ff || !rsp_stall);
   assign hold  = a_valid_ff && !a_adv;

   // Sums for the pixel in the input stage.
   always_comb begin
      is_bin  = (a_desc_ff.kind == KIND_BIN);
      acc_sum = acc_ff + SUM_W'(a_desc_ff.pix);
      prev    = a_desc_ff.blk_first_row ? '0 : (byp_ff ? byp_data_ff : rdata);
      sum     = prev + acc_sum;
      rsum    = {1'b0, sum} + (a_desc_ff.quad ? (SUM_W + 1)'(8) : (SUM_W + 1)'(2));
      mean    = a_desc_ff.quad ? rsum[PIX_W+3:4] : rsum[PIX_W+1:2];
      ram_we  = a_adv && is_bin && a_desc_ff.blk_last_col;
   end

   // Result selection.
   always_comb begin
      case (a_desc_ff.kind)
         KIND_PASS: begin
            emits   = 1'b1;
            res_pix = a_desc_ff.pix;
         end
         KIND_ERR: begin
            emits   = 1'b1;
            res_pix = '0;
         end
         KIND_BIN: begin
            emits   = a_desc_ff.blk_last_col && a_desc_ff.blk_last_row;
            res_pix = mean;
         end
         default: begin
            emits   = 1'b0;
            res_pix = '0;
         end
      endcase
   end

   // Control for both stages and the row accumulator.
   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_adv) begin
         a_valid_in = 1'b0;
      end

      b_valid_in = b_valid_ff;
      if (a_adv && emits) begin
         b_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         b_valid_in = 1'b0;
      end

      acc_in = acc_ff;
      if (a_adv && is_bin) begin
         acc_in = a_desc_ff.blk_last_col ? '0 : acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         acc_ff     <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         acc_ff     <= acc_in;
      end
   end

   // Input stage payload, with a bypass for a read that meets a write.
   always_ff @(posedge clock) begin
      if (accept) begin
         a_desc_ff   <= desc;
         a_addr_ff   <= col_addr;
         byp_ff      <= ram_we && (a_addr_ff == col_addr);
         byp_data_ff <= sum;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (a_adv && emits) begin
         b_pix_ff    <= res_pix;
         b_eor_ff    <= a_desc_ff.last_col;
         b_eof_ff    <= a_desc_ff.last_col && a_desc_ff.last_row;
         b_status_ff <= (a_desc_ff.kind == KIND_ERR);
      end
   end

   assign rsp_valid        = b_valid_ff;
   assign rsp_pixel_out    = b_pix_ff;
   assign rsp_end_of_row   = b_eor_ff;
   assign rsp_end_of_frame = b_eof_ff;
   assign rsp_status       = b_status_ff;

endmodule : abp_accum

`default_nettype wire

// ===== hdl/average_pixel_binning_core.sv =====
// Average pixel binning core, top level. Depends on abp_pkg, abp_raster, abp_accum.
// Throughput: one pixel per clock while the result channel does not stall; every pixel takes one transfer.
// Path: a pixel's result is formed in the input stage (column store read, sum) and then held
// in the result register until it transfers.
// Reset clears the raster counters, row accumulator, stage valids and configuration;
// the column sum store is not cleared and is written before it is read.
`default_nettype none

module average_pixel_binning_core #(
   parameter int MAX_WIDTH  = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [abp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [abp_pkg::DIM_W-1:0]     csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [abp_pkg::PIX_W-1:0]     req_pixel_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [abp_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic                               rsp_end_of_row,
   output logic                               rsp_end_of_frame,
   output logic                               rsp_status
);

   import abp_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH / 2);

   desc_type      desc;
   logic [AW-1:0] col_addr;
   logic          hold;
   logic          accept;

   // A transfer happens whenever the input stage is free or moving on.
   assign req_stall = hold;
   assign accept    = req_valid && !hold;

   abp_raster #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_raster (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .pixel_in  (req_pixel_in),
      .desc      (desc),
      .col_addr  (col_addr)
   );

   abp_accum #(.MAX_WIDTH(MAX_WIDTH)) u_accum (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .desc             (desc),
      .col_addr         (col_addr),
      .hold             (hold),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_end_of_row   (rsp_end_of_row),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_status       (rsp_status)
   );

endmodule : average_pixel_binning_core

`default_nettype wire

// ===== tb/sv/tb_average_pixel_binning_core.sv =====
// Self-checking testbench for average_pixel_binning_core: passthrough, 2x2 and 4x4 averaging,
// geometry errors, dimension clamping and mid-frame reconfiguration, with random back-pressure.
// Depends on abp_pkg and the core RTL; needs no files or arguments.
module tb_average_pixel_binning_core;
   timeunit 1ns;
   timeprecision 1ps;

   import abp_pkg::*;

   localparam int FRAME_MAX_WIDTH = 4096;
   localparam int COLUMN_SLOTS    = FRAME_MAX_WIDTH / 2;
   // The fourth bin mode code is unused and behaves as passthrough.
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_GEOMETRY = 1'b1;
   localparam int DRAIN_CYCLES    = 6;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_PIXELS   = 900;
   localparam int STEADY_PIXELS   = 200;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             row_end;
      logic             frame_end;
      logic             status;
   } out_pixel_type;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 csr_we       = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [DIM_W-1:0]     csr_wdata    = '0;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_pixel_in = '0;
   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b0;
   logic [PIX_W-1:0]     rsp_pixel_out;
   logic                 rsp_end_of_row;
   logic                 rsp_end_of_frame;
   logic                 rsp_status;

   // Configuration and raster state as the core is meant to hold them.
   logic [MODE_W-1:0] cfg_mode;
   logic              cfg_wide;
   logic [DIM_W-1:0]  cfg_width;
   logic [DIM_W-1:0]  cfg_height;
   logic [SUM_W-1:0]  col_sums [COLUMN_SLOTS];
   logic [SUM_W-1:0]  row_acc;
   int unsigned       col_cnt;
   int unsigned       row_cnt;

   // Output pixels predicted but not yet seen on the result channel.
   out_pixel_type outgoing_pixels [$];
   int unsigned   fail_count  = 0;
   int unsigned   pixels_sent = 0;

   // Idling controls shared by the sender, the receiver and the tests.
   bit          tx_gaps_on   = 1'b1;
   bit          rx_stalls_on = 1'b1;
   bit          hold_off_req = 1'b0;
   int unsigned hold_left    = 0;
   int unsigned burst_left   = 0;

   average_pixel_binning_core #(
      .MAX_WIDTH (FRAME_MAX_WIDTH),
      .PIXEL_BITS(PIX_W)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_end_of_row  (rsp_end_of_row),
      .rsp_end_of_frame(rsp_end_of_frame),
      .rsp_status      (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // A hung run ends here.
   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
      if (v == '0) return 1;
      if (32'(v) > hi) return hi;
      return 32'(v);
   endfunction

   function automatic int unsigned eff_width();
      return clamp_dim(cfg_width, FRAME_MAX_WIDTH);
   endfunction

   function automatic int unsigned eff_height();
      return clamp_dim(cfg_height, 32'(MAX_HEIGHT));
   endfunction

   function automatic int unsigned block_size();
      case (cfg_mode)
         MODE_BIN2: return 2;
         MODE_BIN4: return 4;
         default:   return 1;
      endcase
   endfunction

   // True when both raster counters are at zero, so the next pixel opens a frame under any
   // geometry that is written next.
   function automatic bit at_frame_start();
      return (col_cnt == 0) && (row_cnt == 0);
   endfunction

   // Mostly random pixels, with the corner values mixed in.
   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 16'h00FF;
         3:       return 16'hFF00;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // Advance the raster by one accepted pixel and queue the output pixel it produces, if any.
   task automatic bin_pixel(input logic [PIX_W-1:0] pix);
      int unsigned      w, h, k, x, y, col, rounded;
      logic [PIX_W-1:0] p;
      logic [SUM_W-1:0] sum;
      logic             lc, lr, eor;
      out_pixel_type    res;
      bit               emit;
      w    = eff_width();
      h    = eff_height();
      k    = block_size();
      p    = cfg_wide ? pix : {8'h00, pix[7:0]};
      emit = 1'b0;
      if (col_cnt >= w) col_cnt = 0;
      if (row_cnt >= h) row_cnt = 0;
      x  = col_cnt;
      y  = row_cnt;
      lc = (x == w - 1);
      lr = (y == h - 1);
      if (k == 1) begin
         res  = {p, lc, lc && lr, STATUS_OK};
         emit = 1'b1;
      end else if (w % k != 0 || h % k != 0) begin
         res  = {PIX_W'(0), lc, lc && lr, STATUS_GEOMETRY};
         emit = 1'b1;
      end else begin
         row_acc = row_acc + SUM_W'(p);
         // The right column of a block folds the row sum into the column store.
         if (x % k == k - 1) begin
            col = x / k;
            if (col >= COLUMN_SLOTS) col = COLUMN_SLOTS - 1;
            sum = row_acc;
            if (y % k != 0) sum = sum + col_sums[col];
            col_sums[col] = sum;
            row_acc       = '0;
            // The bottom-right pixel emits the rounded mean of the block.
            if (y % k == k - 1) begin
               eor     = (col == w / k - 1);
               rounded = (32'(sum) + k * k / 2) >> $clog2(k * k);
               res     = {PIX_W'(rounded), eor, eor && lr, STATUS_OK};
               emit    = 1'b1;
            end
         end
      end
      if (emit) outgoing_pixels.push_back(res);
      if (lc) begin
         col_cnt = 0;
         row_cnt = lr ? 0 : y + 1;
      end else begin
         col_cnt = x + 1;
      end
   endtask

   // Offer one pixel, sometimes after an idle burst, and wait for its transfer.
   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (req_stall);
      bin_pixel(pix);
      pixels_sent++;
   endtask

   task automatic send_frames(input int unsigned frames);
      repeat (frames * eff_width() * eff_height()) send_pixel(random_pixel());
   endtask

   task automatic finish_frame();
      while (!at_frame_start()) send_pixel(random_pixel());
   endtask

   // Drop valid and let every pending output pixel and any pixel still in flight drain.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outgoing_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [DIM_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BIN_MODE:     cfg_mode   = value[MODE_W-1:0];
         CSR_PIXEL_WIDE:   cfg_wide   = value[0];
         CSR_FRAME_WIDTH:  cfg_width  = value;
         CSR_FRAME_HEIGHT: cfg_height = value;
         default: ;
      endcase
   endtask

   task automatic set_geometry(input logic [MODE_W-1:0] mode, input logic wide,
                               input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height);
      wait_idle();
      write_csr(CSR_BIN_MODE, DIM_W'(mode));
      write_csr(CSR_PIXEL_WIDE, DIM_W'(wide));
      write_csr(CSR_FRAME_WIDTH, width);
      write_csr(CSR_FRAME_HEIGHT, height);
   endtask

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
   endtask

   // Receiver: random stall bursts, plus one long hold-off when a test asks for it.
   always @(negedge clock) begin
      if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (burst_left != 0) begin
         burst_left = burst_left - 1;
         rsp_stall  <= 1'b1;
      end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
         burst_left = $urandom_range(0, 14);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every output transfer is matched against the oldest predicted pixel.
   always @(posedge clock) begin : check_outputs
      out_pixel_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (outgoing_pixels.size() == 0) begin
            log_failure($sformatf("unexpected output pixel %h eor %b eof %b status %b",
                                  rsp_pixel_out, rsp_end_of_row, rsp_end_of_frame,
                                  rsp_status));
         end else begin
            want = outgoing_pixels.pop_front();
            if (rsp_pixel_out !== want.pixel || rsp_end_of_row !== want.row_end ||
                rsp_end_of_frame !== want.frame_end || rsp_status !== want.status) begin
               log_failure($sformatf({"output mismatch: expected pixel %h eor %b eof %b ",
                                      "status %b, got pixel %h eor %b eof %b status %b"},
                                     want.pixel, want.row_end, want.frame_end, want.status,
                                     rsp_pixel_out, rsp_end_of_row, rsp_end_of_frame,
                                     rsp_status));
            end
         end
      end
   end

   // Reset configuration: 1x1 frames of 8-bit passthrough pixels.
   task automatic test_reset_defaults();
      send_pixel(16'hFFFF);
      send_pixel(16'h1234);
   endtask

   task automatic test_passthrough();
      set_geometry(MODE_PASS, 1'b1, 13'd3, 13'd2);
      send_pixel(16'h0000);
      send_pixel(16'hFFFF);
      send_pixel(16'h8000);
      send_pixel(16'h0001);
      send_pixel(16'h7FFF);
      send_pixel(16'h5555);
      set_geometry(MODE_SPARE, 1'b0, 13'd2, 13'd1);
      send_pixel(16'hABCD);
      send_pixel(16'h12FF);
   endtask

   // A full-scale block and a block whose mean rounds up from three quarters.
   task automatic test_bin2_mean();
      set_geometry(MODE_BIN2, 1'b1, 13'd4, 13'd2);
      for (int r = 0; r < 2; r++) begin
         send_pixel(16'hFFFF);
         send_pixel(16'hFFFF);
         send_pixel(16'h0001);
         send_pixel(r == 0 ? 16'h0000 : 16'h0001);
      end
   endtask

   // Eight ones in a 4x4 block sit exactly on the rounding point; high bytes are masked off.
   task automatic test_bin4_rounding();
      set_geometry(MODE_BIN4, 1'b0, 13'd4, 13'd4);
      for (int i = 0; i < 16; i++) send_pixel(i < 8 ? 16'hA501 : 16'h5A00);
   endtask

   task automatic test_geometry_error();
      set_geometry(MODE_BIN2, 1'b1, 13'd3, 13'd2);
      send_frames(1);
      set_geometry(MODE_BIN4, 1'b0, 13'd4, 13'd2);
      send_frames(1);
   endtask

   // Zero dimensions act as one, oversized ones as the maximum.
   task automatic test_geometry_clamp();
      set_geometry(MODE_PASS, 1'b1, 13'd0, 13'd0);
      repeat (3) send_pixel(random_pixel());
      // An oversized width keeps the first pixels of a row away from its end.
      set_geometry(MODE_PASS, 1'b0, 13'h1FFF, 13'd1);
      repeat (5) send_pixel(random_pixel());
      // An oversized height keeps the first rows away from the end of the frame.
      set_geometry(MODE_PASS, 1'b1, 13'd1, 13'h1FFF);
      repeat (5) send_pixel(random_pixel());
   endtask

   // Geometry and mode changes in the middle of a frame; counters past the new limit restart.
   task automatic test_midframe_change();
      set_geometry(MODE_PASS, 1'b1, 13'd8, 13'd4);
      repeat (13) send_pixel(random_pixel());
      wait_idle();
      write_csr(CSR_FRAME_WIDTH, 13'd3);
      repeat (2) send_pixel(random_pixel());
      wait_idle();
      write_csr(CSR_FRAME_HEIGHT, 13'd1);
      repeat (2) send_pixel(random_pixel());
      wait_idle();
      write_csr(CSR_BIN_MODE, DIM_W'(MODE_BIN2));
      finish_frame();
   endtask

   // The receiver holds off long enough for the core to fill and stall its input.
   task automatic test_backpressure();
      set_geometry(MODE_PASS, 1'b1, 13'd16, 13'd4);
      @(posedge clock);
      hold_off_req = 1'b1;
      send_frames(1);
   endtask

   // Mostly well-formed binning frames, with broken geometry and passthrough frames, some cut short.
   task automatic test_random_frames(input int unsigned pixel_budget, input bit quiet);
      int unsigned       stop_at, k, pick, w, h;
      logic [MODE_W-1:0] mode;
      stop_at = pixels_sent + pixel_budget;
      while (pixels_sent < stop_at) begin
         tx_gaps_on   = !quiet && $urandom_range(0, 3) != 0;
         rx_stalls_on = !quiet && $urandom_range(0, 3) != 0;
         pick = $urandom_range(0, 9);
         mode = $urandom_range(0, 1) ? MODE_BIN2 : MODE_BIN4;
         k    = (mode == MODE_BIN2) ? 2 : 4;
         if (pick < 7) begin
            w = k * $urandom_range(1, 8);
            h = k * $urandom_range(1, (k == 2) ? 4 : 2);
            set_geometry(mode, 1'($urandom_range(0, 1)), DIM_W'(w), DIM_W'(h));
            send_frames($urandom_range(1, 2));
         end else if (pick == 7) begin
            // One dimension is off the block grid.
            w = k * $urandom_range(1, 4);
            h = k * $urandom_range(1, 2);
            if ($urandom_range(0, 1)) w = w + $urandom_range(1, k - 1);
            else h = h + $urandom_range(1, k - 1);
            set_geometry(mode, 1'($urandom_range(0, 1)), DIM_W'(w), DIM_W'(h));
            send_frames(1);
         end else begin
            mode = $urandom_range(0, 1) ? MODE_PASS : MODE_SPARE;
            set_geometry(mode, 1'($urandom_range(0, 1)), DIM_W'($urandom_range(1, 12)),
                         DIM_W'($urandom_range(1, 4)));
            if (pick == 9) begin
               repeat ($urandom_range(1, eff_width() * eff_height())) send_pixel(random_pixel());
               wait_idle();
               write_csr(CSR_FRAME_WIDTH, DIM_W'($urandom_range(1, 12)));
               finish_frame();
            end else begin
               send_frames(1);
            end
         end
      end
      tx_gaps_on   = !quiet;
      rx_stalls_on = !quiet;
   endtask

   initial begin
      cfg_mode   = MODE_PASS;
      cfg_wide   = 1'b0;
      cfg_width  = 13'd1;
      cfg_height = 13'd1;
      row_acc    = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      foreach (col_sums[i]) col_sums[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_passthrough();
      test_bin2_mean();
      test_bin4_rounding();
      test_geometry_error();
      test_geometry_clamp();
      test_midframe_change();
      test_backpressure();
      test_random_frames(RANDOM_PIXELS, 1'b0);
      test_random_frames(STEADY_PIXELS, 1'b1);
      wait_idle();

      if (fail_count == 0 && outgoing_pixels.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/abp_pkg.sv
hdl/abp_ram.sv
hdl/abp_raster.sv
hdl/abp_accum.sv
hdl/average_pixel_binning_core.sv
tb/sv/tb_average_pixel_binning_core.sv
